>>> rtl/mbs_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the multipart boundary scanner
package mbs_pkg;

  localparam int MAX_BOUNDARY_DEFAULT = 60;
  localparam int PREFIX_LEN           = 4;
  localparam int COUNT_W              = 7;
  localparam int FLUSH_W              = 6;
  localparam int QUEUE_DEPTH          = 2;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_DATA    = 2'd1,
    ACT_END     = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_DASH = 8'h2D;

  typedef struct packed {
    action_t     action;
    logic [5:0]  index;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               found;
  } back_status_t;

  // fixed delimiter head: CR LF dash dash
  function automatic logic [7:0] prefix_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = BYTE_CR;
      2'd1:    b = BYTE_LF;
      default: b = BYTE_DASH;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/mbs_front.sv
`timescale 1ns / 1ps
// front end: takes input transfers, drops loads outside the store, feeds the queue
module mbs_front #(
  parameter int MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEFAULT
) (
  input  logic          item_valid,
  output logic          item_stall,
  input  mbs_pkg::item_t item,
  input  logic          queue_full,
  output logic          push,
  output mbs_pkg::item_t push_item
);
  import mbs_pkg::*;

  logic drop;

  // a load beyond the store is taken and forgotten
  assign drop       = (item.action == ACT_LOAD) && (int'(item.index) >= MAX_BOUNDARY);
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full && !drop;
  assign push_item  = item;

endmodule

>>> rtl/mbs_queue.sv
`timescale 1ns / 1ps
// small queue between the front end and the scan engine
module mbs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbs_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output mbs_pkg::item_t pop_item
);
  import mbs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/mbs_back.sv
`timescale 1ns / 1ps
// scan engine: boundary store, delimiter match, flush sequencer and result register
module mbs_back #(
  parameter int MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [5:0]           cfg_data,
  input  logic                 q_valid,
  input  mbs_pkg::item_t       q_item,
  output logic                 q_pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output mbs_pkg::result_t     result,
  output mbs_pkg::back_status_t status
);
  import mbs_pkg::*;

  localparam int AW = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;

  typedef enum logic [3:0] {
    ST_FETCH = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_TAIL  = 4'b1000
  } state_t;

  logic [7:0]          store [MAX_BOUNDARY];
  logic [7:0]          rdata;

  state_t              state, state_next;
  item_t               cur;
  logic [COUNT_W-1:0]  match_count, match_count_next;
  logic                found, found_next;
  logic [FLUSH_W-1:0]  flush_idx, flush_idx_next;
  logic [5:0]          boundary_length;
  result_t             out_item;
  logic                out_valid;

  logic [5:0]          len_clamped;
  logic [COUNT_W-1:0]  delim_len;
  logic [COUNT_W-1:0]  count_inc;
  logic [COUNT_W-1:0]  exp_pos;
  logic [7:0]          exp_byte;
  logic                out_free;
  logic                emit;
  result_t             emit_item;
  logic                rd_en;
  logic [COUNT_W-1:0]  rd_pos;
  logic [COUNT_W-1:0]  rd_off;
  logic                rd_ok;
  logic                wr_en;
  logic                cur_is_cr;
  logic                flush_final;

  assign len_clamped = (int'(boundary_length) > MAX_BOUNDARY) ? 6'(MAX_BOUNDARY)
                                                              : boundary_length;
  assign delim_len   = COUNT_W'(PREFIX_LEN) + COUNT_W'(len_clamped);
  assign count_inc   = match_count + COUNT_W'(1);
  assign out_free    = !out_valid || !result_stall;
  assign cur_is_cr   = (cur.data == BYTE_CR);
  assign flush_final = (COUNT_W'(flush_idx) + COUNT_W'(1) == match_count);

  // expected delimiter byte at the current position
  assign exp_pos  = state[2] ? COUNT_W'(flush_idx) : match_count;
  assign exp_byte = (exp_pos < COUNT_W'(PREFIX_LEN)) ? prefix_byte(exp_pos[1:0]) : rdata;

  assign rd_off = rd_pos - COUNT_W'(PREFIX_LEN);
  assign rd_ok  = (rd_pos >= COUNT_W'(PREFIX_LEN)) && (int'(rd_off) < MAX_BOUNDARY);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cur.index[AW-1:0]] <= cur.data;
    end
    if (rd_en && rd_ok) begin
      rdata <= store[rd_off[AW-1:0]];
    end
  end

  always_comb begin
    state_next       = state;
    match_count_next = match_count;
    found_next       = found;
    flush_idx_next   = flush_idx;
    q_pop            = 1'b0;
    emit             = 1'b0;
    emit_item        = '{kind: KIND_DATA, out_byte: 8'h00, last: 1'b1};
    rd_en            = 1'b0;
    rd_pos           = match_count;
    wr_en            = 1'b0;

    unique case (state)
      ST_FETCH: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cur.action)
          ACT_LOAD: begin
            wr_en      = 1'b1;
            state_next = ST_FETCH;
          end
          ACT_RESTART: begin
            match_count_next = '0;
            found_next       = 1'b0;
            state_next       = ST_FETCH;
          end
          ACT_END: begin
            if (found) begin
              state_next = ST_FETCH;
            end else if (out_free) begin
              emit             = 1'b1;
              emit_item.kind   = KIND_END;
              match_count_next = '0;
              state_next       = ST_FETCH;
            end
          end
          default: begin
            if (found) begin
              state_next = ST_FETCH;
            end else if (match_count >= delim_len) begin
              // length shortened while holding
              if (out_free) begin
                emit           = 1'b1;
                emit_item.kind = KIND_FOUND;
                found_next     = 1'b1;
                state_next     = ST_FETCH;
              end
            end else if (cur.data == exp_byte) begin
              if (count_inc == delim_len) begin
                if (out_free) begin
                  emit             = 1'b1;
                  emit_item.kind   = KIND_FOUND;
                  found_next       = 1'b1;
                  match_count_next = count_inc;
                  state_next       = ST_FETCH;
                end
              end else begin
                match_count_next = count_inc;
                state_next       = ST_FETCH;
              end
            end else if (match_count == '0) begin
              if (out_free) begin
                emit               = 1'b1;
                emit_item.out_byte = cur.data;
                state_next         = ST_FETCH;
              end
            end else begin
              flush_idx_next = '0;
              state_next     = ST_FLUSH;
            end
          end
        endcase
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_item.out_byte = exp_byte;
          emit_item.last     = flush_final && cur_is_cr;
          if (flush_final) begin
            match_count_next = cur_is_cr ? COUNT_W'(1) : '0;
            state_next       = cur_is_cr ? ST_FETCH : ST_TAIL;
          end else begin
            flush_idx_next = flush_idx + FLUSH_W'(1);
            rd_en          = 1'b1;
            rd_pos         = COUNT_W'(flush_idx) + COUNT_W'(1);
          end
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_item.out_byte = cur.data;
          state_next         = ST_FETCH;
        end
      end
      default: begin
        state_next = ST_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (emit) begin
      out_item <= emit_item;
    end
    flush_idx <= flush_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_FETCH;
      match_count     <= '0;
      found           <= 1'b0;
      boundary_length <= '0;
      out_valid       <= 1'b0;
    end else begin
      state       <= state_next;
      match_count <= match_count_next;
      found       <= found_next;
      if (cfg_write) begin
        boundary_length <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_valid       = out_valid;
  assign result             = out_item;
  assign status.match_count = match_count;
  assign status.found       = found;

endmodule

>>> rtl/multipart_boundary_scanner_unit.sv
`timescale 1ns / 1ps
// top level of the multipart boundary scanner
//
// Scans a byte stream for CR LF "--" followed by a boundary string of
// cfg_data bytes (values above MAX_BOUNDARY count as MAX_BOUNDARY). Boundary
// bytes are loaded as items (action 0) and must be loaded before the scan
// reads them. Bytes that match so far are held back; on a mismatch the held
// bytes come out in order, then the current byte either starts a new hold
// (it is CR) or comes out too. A full match gives one "found" result, and
// data is ignored until a restart item. End of stream before a match gives
// one "ended" result and drops the held bytes. In the scan engine each item
// goes through a queue pop with boundary store read, then a compare; on a
// mismatch the held bytes are flushed, then the mismatching byte comes out
// unless it is a CR that starts a new hold; the flush reads the single store
// port one position per cycle while the result side does not stall. A
// two-entry queue sits between the input and the engine, so input transfers
// are still taken while a result waits in the output register, until the
// queue is full. Write the length register only while idle.
module multipart_boundary_scanner_unit #(
  parameter int MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  // input item channel
  input  logic             item_valid,
  output logic             item_stall,
  input  mbs_pkg::item_t   item,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output mbs_pkg::result_t result,
  // boundary length register
  input  logic             cfg_write,
  input  logic [5:0]       cfg_data
);
  import mbs_pkg::*;

  logic          queue_full;
  logic          push;
  item_t         push_item;
  logic          pop;
  logic          pop_valid;
  item_t         pop_item;
  back_status_t  status;

  // classify and hand to the queue
  mbs_front #(
    .MAX_BOUNDARY(MAX_BOUNDARY)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // decouples input transfers from the scan engine
  mbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  // match, flush and result register
  mbs_back #(
    .MAX_BOUNDARY(MAX_BOUNDARY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .q_valid      (pop_valid),
    .q_item       (pop_item),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .status       (status)
  );

  // hold count never passes the longest delimiter
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(status.match_count) <= PREFIX_LEN + MAX_BOUNDARY)
    else $error("match count beyond longest delimiter");

  // no passed-through byte once the boundary was found
  a_no_data_after_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_DATA) |-> !status.found)
    else $error("data result after boundary found");

  // found flag rises together with the found result
  a_found_reported: assert property (@(posedge clk) disable iff (rst)
    $rose(status.found) |-> result_valid && (result.kind == KIND_FOUND) && result.last)
    else $error("found flag set without found result");

endmodule

>>> dv/boundary_scan_scoreboard.sv
`timescale 1ns / 1ps
// scoreboard for the multipart boundary scanner: predicts results per transfer and compares
module boundary_scan_scoreboard (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  mbs_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  mbs_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [5:0]       cfg_data,
  output int               mismatch_count,
  output int               results_due
);
  import mbs_pkg::*;

  localparam int MAX_BOUNDARY = MAX_BOUNDARY_DEFAULT;

  logic [7:0] pattern_store [MAX_BOUNDARY];
  logic [5:0] length_reg;
  logic [6:0] held_count;
  logic       boundary_seen;
  result_t    expected_results [$];

  function automatic logic [7:0] delimiter_byte(input int pos);
    case (pos)
      0:       return BYTE_CR;
      1:       return BYTE_LF;
      2, 3:    return BYTE_DASH;
      default: return pattern_store[pos - PREFIX_LEN];
    endcase
  endfunction

  task automatic predict_scan(input item_t it);
    result_t batch [$];
    int      span;
    span = PREFIX_LEN + ((length_reg > MAX_BOUNDARY) ? MAX_BOUNDARY : int'(length_reg));
    case (it.action)
      ACT_LOAD: begin
        if (it.index < MAX_BOUNDARY) pattern_store[it.index] = it.data;
      end
      ACT_DATA: begin
        if (!boundary_seen) begin
          if (held_count >= span) begin
            // length shrank under a hold that already covers it
            boundary_seen = 1'b1;
            batch.push_back('{kind: KIND_FOUND, out_byte: 8'h00, last: 1'b0});
          end else if (it.data == delimiter_byte(int'(held_count))) begin
            held_count = held_count + 7'd1;
            if (held_count >= span) begin
              boundary_seen = 1'b1;
              batch.push_back('{kind: KIND_FOUND, out_byte: 8'h00, last: 1'b0});
            end
          end else begin
            for (int i = 0; i < int'(held_count); i++)
              batch.push_back('{kind: KIND_DATA, out_byte: delimiter_byte(i), last: 1'b0});
            held_count = '0;
            if (it.data == delimiter_byte(0))
              held_count = 7'd1;
            else
              batch.push_back('{kind: KIND_DATA, out_byte: it.data, last: 1'b0});
          end
        end
      end
      ACT_END: begin
        if (!boundary_seen) begin
          held_count = '0;
          batch.push_back('{kind: KIND_END, out_byte: 8'h00, last: 1'b0});
        end
      end
      default: begin
        held_count    = '0;
        boundary_seen = 1'b0;
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: result with none due, expected none actual kind %0d byte %02h last %0b",
               $time, got.kind, got.out_byte, got.last);
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind) begin
        mismatch_count++;
        $display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind, got.kind);
      end
      if (got.out_byte !== want.out_byte) begin
        mismatch_count++;
        $display("%0t: out_byte mismatch, expected %02h actual %02h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.last !== want.last) begin
        mismatch_count++;
        $display("%0t: last mismatch, expected %0b actual %0b", $time, want.last, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      length_reg     = '0;
      held_count     = '0;
      boundary_seen  = 1'b0;
      mismatch_count = 0;
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) check_result(result);
      if (cfg_write) length_reg = cfg_data;
      if (item_valid && !item_stall) predict_scan(item);
    end
    results_due = expected_results.size();
  end

endmodule

>>> dv/multipart_boundary_scanner_unit_tb.sv
`timescale 1ns / 1ps
// testbench top for the multipart boundary scanner: stimulus, idling and verdict
module multipart_boundary_scanner_unit_tb;
  import mbs_pkg::*;

  localparam int MAX_BOUNDARY = MAX_BOUNDARY_DEFAULT;
  // quiet cycles after the last due result: covers the input queue and the engine, with margin
  localparam int DRAIN_CYCLES = 32;

  logic       clk;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  item_t      item         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_write    = 1'b0;
  logic [5:0] cfg_data     = '0;

  int mismatch_count;
  int results_due;

  // idle rates in percent, changed per phase
  int send_idle_pct = 13;
  int recv_idle_pct = 84;

  // stimulus-side copy of the boundary, used only to build delimiters
  logic [7:0] boundary_bytes [MAX_BOUNDARY];
  bit         loaded [MAX_BOUNDARY];
  int         scan_length = 0;

  // register settings walked through, five per idle phase; 63 clamps to the maximum
  int lengths [15] = '{1, 0, 5, 60, 2, 3, 63, 0, 12, 1, 2, 42, 6, 0, 3};

  multipart_boundary_scanner_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  boundary_scan_scoreboard scoreboard (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side stall, redrawn every cycle
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // byte at a delimiter position: fixed head, then the loaded boundary
  function automatic logic [7:0] pattern_byte(input int pos);
    if (pos < PREFIX_LEN) return prefix_byte(pos[1:0]);
    return boundary_bytes[pos - PREFIX_LEN];
  endfunction

  // stream byte biased toward delimiter bytes so holds start often
  function automatic logic [7:0] pick_stream_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return BYTE_CR;
    if (r < 35) return BYTE_LF;
    if (r < 45) return BYTE_DASH;
    if (r < 60 && scan_length > 0) return boundary_bytes[$urandom_range(scan_length - 1)];
    return 8'($urandom_range(255));
  endfunction

  // one transfer on the item channel; valid stays up between back-to-back transfers
  task automatic send_item(input action_t act, input logic [5:0] idx, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{action: act, index: idx, data: b};
    do begin
      @(posedge clk);
    end while (item_stall);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(ACT_DATA, 6'($urandom_range(63)), b);
  endtask

  task automatic load_boundary(input logic [5:0] idx, input logic [7:0] b);
    send_item(ACT_LOAD, idx, b);
    if (idx < MAX_BOUNDARY) begin
      boundary_bytes[idx] = b;
      loaded[idx]         = 1'b1;
    end
  endtask

  // wait until every due result has come, then let loads and holds settle
  task automatic drain_scanner();
    item_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // every boundary byte the new length reaches is loaded before the register changes
  task automatic set_boundary_length(input logic [5:0] n);
    int reach;
    reach = (n > MAX_BOUNDARY) ? MAX_BOUNDARY : int'(n);
    for (int p = 0; p < reach; p++)
      if (!loaded[p]) load_boundary(6'(p), 8'($urandom_range(255)));
    drain_scanner();
    cfg_write <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    cfg_write <= 1'b0;
    scan_length = reach;
  endtask

  // mostly delimiter attempts with random content, cut short or complete,
  // mixed with stream ends, restarts, loads and plain noise
  task automatic run_stream_traffic(input int budget);
    int counted;
    int choice;
    int span;
    int cut;
    logic [5:0] idx;
    counted = 0;
    while (counted < budget) begin
      choice = $urandom_range(99);
      if (choice < 55) begin
        repeat ($urandom_range(3)) begin
          send_byte(pick_stream_byte());
          counted++;
        end
        span = PREFIX_LEN + scan_length;
        case ($urandom_range(3))
          0:       cut = span;
          1:       cut = span - 1;
          default: cut = $urandom_range(span);
        endcase
        for (int p = 0; p < cut; p++) begin
          send_byte(pattern_byte(p));
          counted++;
        end
        if (cut == span) begin
          // boundary found: data and end of stream are dropped until restart
          if ($urandom_range(1)) send_byte(pick_stream_byte());
          if ($urandom_range(1))
            send_item(ACT_END, 6'($urandom_range(63)), 8'($urandom_range(255)));
          send_item(ACT_RESTART, 6'($urandom_range(63)), 8'($urandom_range(255)));
          counted++;
        end else begin
          // breaking byte; may well extend the match instead
          send_byte(pick_stream_byte());
          counted++;
        end
      end else if (choice < 68) begin
        send_item(ACT_END, 6'($urandom_range(63)), 8'($urandom_range(255)));
        counted++;
        if ($urandom_range(1)) begin
          send_item(ACT_RESTART, 6'($urandom_range(63)), 8'($urandom_range(255)));
          counted++;
        end
      end else if (choice < 76) begin
        send_item(ACT_RESTART, 6'($urandom_range(63)), 8'($urandom_range(255)));
        counted++;
      end else if (choice < 88) begin
        // any index, out-of-range ones included
        idx = 6'($urandom_range(63));
        load_boundary(idx, 8'($urandom_range(255)));
        if (idx < MAX_BOUNDARY) counted++;
      end else begin
        send_byte(8'($urandom_range(255)));
        counted++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part, boundary length zero after reset: delimiter is CR LF dash dash
    send_item(ACT_DATA, 6'd0, 8'h00);
    send_item(ACT_DATA, 6'd63, 8'hFF);
    load_boundary(6'd63, 8'hA5);          // index past the store, dropped
    load_boundary(6'd0, 8'h5A);
    load_boundary(6'd59, 8'hFF);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_byte(BYTE_DASH);
    send_byte(BYTE_DASH);                 // completes the match
    send_byte(8'h41);                     // dropped after found
    send_item(ACT_END, 6'd0, 8'h00);      // dropped after found
    send_item(ACT_RESTART, 6'd0, 8'h00);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_byte(8'h37);                     // mismatch: CR LF flushed, then the byte
    send_byte(BYTE_CR);
    send_byte(BYTE_CR);                   // mismatch on a CR: flush one, hold again
    send_item(ACT_END, 6'd0, 8'h00);      // end before match drops the held CR
    set_boundary_length(6'd2);
    for (int p = 0; p < PREFIX_LEN + 1; p++) send_byte(pattern_byte(p));
    // length shrinks under the hold, so the next byte reports found
    set_boundary_length(6'd1);
    send_byte(8'h00);
    send_item(ACT_RESTART, 6'd0, 8'h00);

    // three idle phases: slow receiver, slow sender, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 5; s++) begin
        set_boundary_length(6'(lengths[ph * 5 + s]));
        // long boundaries make long sequences, so they get fewer bursts
        run_stream_traffic((scan_length > 8) ? 2 : 12);
      end
    end

    drain_scanner();
    if (mismatch_count == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard limit well beyond the slowest passing run
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
